@@ rtl/afro_pkg.sv @@
// afro_pkg: shared types and codes of the overlapping audio frame ring
// used by afro_ctrl, afro_dp and the top level; no dependencies
`default_nettype none

package afro_pkg;

    localparam int SAMPLE_W = 21;
    localparam int HOP_W    = 7;
    localparam int HELD_W   = 4;
    localparam int STAT_W   = 3;
    localparam int MODE_W   = 2;
    localparam int RAW_W    = 32;
    localparam int SHIFT    = 11;
    localparam logic [HOP_W-1:0] HOP_RESET = 7'd32;

    // request modes
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OVERLAP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OFFRST  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_SAMPLE = 3'd0;
    localparam logic [STAT_W-1:0] ST_STORED = 3'd1;
    localparam logic [STAT_W-1:0] ST_LOST   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FEW    = 3'd3;
    localparam logic [STAT_W-1:0] ST_DONE   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic              push_single;
        logic [STAT_W-1:0] single_st;
        logic              do_write;
        logic              clr_offset;
        logic              start_run;
        logic              run_zero;
        logic              run_at_next;
        logic              run_retire;
        logic              run_set_offset;
        logic              step;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic              hop_ok;
        logic              next_zero;
        logic              held_ge1;
        logic              held_ge2;
        logic              can_issue;
        logic              run_last;
        logic [STAT_W-1:0] wr_status;
    } dp_sts_t;

    typedef struct packed {
        logic [HELD_W-1:0]   held;
        logic [STAT_W-1:0]   status;
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/afro_ctrl.sv @@
// afro_ctrl: request decoder and run sequencer of the frame ring
// depends on afro_pkg; drives afro_dp through dp_cmd_t
`default_nettype none

module afro_ctrl
    import afro_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [MODE_W-1:0] mode,
    input  wire dp_sts_t           sts,
    output dp_cmd_t                cmd
);

    ctrl_state_t state_reg, state_next;
    logic        take;

    assign s_tready = (state_reg == S_IDLE) && sts.can_issue;
    assign take     = s_tready && s_tvalid;

    always_comb begin
        cmd        = '0;
        cmd.single_st = ST_DONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (take) begin
                    case (mode)
                        MODE_WRITE: begin
                            cmd.do_write    = 1'b1;
                            cmd.push_single = 1'b1;
                            cmd.single_st   = sts.wr_status;
                        end
                        MODE_OVERLAP: begin
                            if (!sts.hop_ok) begin
                                cmd.start_run = 1'b1;
                                cmd.run_zero  = 1'b1;
                            end else if (sts.next_zero) begin
                                if (sts.held_ge1) begin
                                    cmd.start_run      = 1'b1;
                                    cmd.run_set_offset = 1'b1;
                                end else begin
                                    cmd.push_single = 1'b1;
                                    cmd.single_st   = ST_FEW;
                                end
                            end else if (sts.held_ge2) begin
                                cmd.start_run      = 1'b1;
                                cmd.run_at_next    = 1'b1;
                                cmd.run_retire     = 1'b1;
                                cmd.run_set_offset = 1'b1;
                            end else begin
                                cmd.push_single = 1'b1;
                                cmd.single_st   = ST_FEW;
                            end
                        end
                        MODE_POP: begin
                            if (sts.held_ge1) begin
                                cmd.start_run  = 1'b1;
                                cmd.run_retire = 1'b1;
                            end else begin
                                cmd.push_single = 1'b1;
                                cmd.single_st   = ST_FEW;
                            end
                        end
                        MODE_OFFRST: begin
                            cmd.clr_offset  = 1'b1;
                            cmd.push_single = 1'b1;
                            cmd.single_st   = ST_DONE;
                        end
                        default: begin
                            cmd.push_single = 1'b1;
                        end
                    endcase
                    if (cmd.start_run) begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (sts.can_issue) begin
                    cmd.step = 1'b1;
                    if (sts.run_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/afro_dp.sv @@
// afro_dp: frame store, ring pointers, overlap offset and result queue
// depends on afro_pkg; commanded by afro_ctrl
`default_nettype none

module afro_dp
    import afro_pkg::*;
#(
    parameter int FRAME_LEN  = 64,
    parameter int RING_SLOTS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [RAW_W-1:0]  raw_word,
    input  wire logic              cfg_we,
    input  wire logic [HOP_W-1:0]  cfg_hop,
    input  wire dp_cmd_t           cmd,
    output dp_sts_t                sts,
    input  wire logic              pop,
    output logic                   out_valid,
    output result_t                out_res
);

    localparam int PW    = $clog2(FRAME_LEN);
    localparam int SW    = $clog2(RING_SLOTS);
    localparam int DEPTH = RING_SLOTS << PW;
    localparam logic [PW-1:0] POS_LAST  = PW'(FRAME_LEN - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(RING_SLOTS - 1);

    // frame store
    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // ring state
    logic [SW-1:0]     wslot_reg, rslot_reg;
    logic [SW-1:0]     wslot_inc, rslot_inc;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [PW-1:0]     fill_reg;
    logic [PW-1:0]     offset_reg;
    logic [HOP_W-1:0]  hop_reg;
    logic              fill_last, ring_full;

    // overlap offset arithmetic
    logic [7:0]    off_sum, off_wrap;
    logic [PW-1:0] next_pos;

    // run sequencing
    logic [PW-1:0]     run_pos_reg, run_cnt_reg;
    logic [SW-1:0]     run_slot_reg;
    logic              run_zero_reg;
    logic [HELD_W-1:0] run_held_reg;

    // read stage and result queue
    logic              s1_v_reg, s1_zero_reg, s1_last_reg;
    logic [STAT_W-1:0] s1_st_reg;
    logic [HELD_W-1:0] s1_held_reg;
    result_t           q_reg [2];
    logic              q_wptr_reg, q_rptr_reg;
    logic [1:0]        q_cnt_reg;
    logic [2:0]        occ;
    result_t           enq_res;

    assign wslot_inc = (wslot_reg == SLOT_LAST) ? '0 : wslot_reg + 1'b1;
    assign rslot_inc = (rslot_reg == SLOT_LAST) ? '0 : rslot_reg + 1'b1;
    assign fill_last = (fill_reg == POS_LAST);
    assign ring_full = (wslot_inc == rslot_reg);

    assign off_sum  = 8'(offset_reg) + 8'(hop_reg);
    assign off_wrap = (off_sum >= 8'(FRAME_LEN)) ? off_sum - 8'(FRAME_LEN) : off_sum;
    assign next_pos = off_wrap[PW-1:0];

    always_comb begin
        held_next = held_reg;
        if (cmd.do_write && fill_last && !ring_full) begin
            held_next = held_reg + 1'b1;
        end else if (cmd.start_run && cmd.run_retire) begin
            held_next = held_reg - 1'b1;
        end
    end

    assign occ = 3'(q_cnt_reg) + 3'(s1_v_reg) - 3'(pop);

    always_comb begin
        sts.hop_ok    = (hop_reg != '0) && (hop_reg <= HOP_W'(FRAME_LEN));
        sts.next_zero = (off_wrap == 8'd0);
        sts.held_ge1  = (held_reg != '0);
        sts.held_ge2  = (held_reg > 4'd1);
        sts.can_issue = (occ < 3'd2);
        sts.run_last  = (run_cnt_reg == POS_LAST);
        sts.wr_status = !fill_last ? ST_DONE : (ring_full ? ST_LOST : ST_STORED);
    end

    // frame store write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.do_write) begin
            mem[{wslot_reg, fill_reg}] <= raw_word[RAW_W-1:SHIFT];
        end
        rd_data_reg <= mem[{run_slot_reg, run_pos_reg}];
    end

    // ring pointers, offset, hop register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wslot_reg  <= '0;
            rslot_reg  <= '0;
            held_reg   <= '0;
            fill_reg   <= '0;
            offset_reg <= '0;
            hop_reg    <= HOP_RESET;
        end else begin
            held_reg <= held_next;
            if (cfg_we) begin
                hop_reg <= cfg_hop;
            end
            if (cmd.do_write) begin
                fill_reg <= fill_last ? '0 : fill_reg + 1'b1;
                if (fill_last) begin
                    wslot_reg <= wslot_inc;
                    if (ring_full) begin
                        rslot_reg <= rslot_inc;
                    end
                end
            end
            if (cmd.start_run && cmd.run_retire) begin
                rslot_reg <= rslot_inc;
            end
            if (cmd.clr_offset) begin
                offset_reg <= '0;
            end else if (cmd.start_run && cmd.run_set_offset) begin
                offset_reg <= next_pos;
            end
        end
    end

    // run position and slot walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_cnt_reg <= '0;
        end else if (cmd.start_run) begin
            run_cnt_reg <= '0;
        end else if (cmd.step) begin
            run_cnt_reg <= run_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_run) begin
            run_slot_reg <= rslot_reg;
            run_pos_reg  <= cmd.run_at_next ? next_pos : '0;
            run_zero_reg <= cmd.run_zero;
            run_held_reg <= held_next;
        end else if (cmd.step) begin
            if (run_pos_reg == POS_LAST) begin
                run_pos_reg  <= '0;
                run_slot_reg <= (run_slot_reg == SLOT_LAST) ? '0 : run_slot_reg + 1'b1;
            end else begin
                run_pos_reg <= run_pos_reg + 1'b1;
            end
        end
    end

    // read stage, lines up with rd_data_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= cmd.push_single || cmd.step;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            s1_zero_reg <= run_zero_reg;
            s1_last_reg <= sts.run_last;
            s1_st_reg   <= ST_SAMPLE;
            s1_held_reg <= run_held_reg;
        end else begin
            s1_zero_reg <= 1'b1;
            s1_last_reg <= 1'b1;
            s1_st_reg   <= cmd.single_st;
            s1_held_reg <= held_next;
        end
    end

    always_comb begin
        enq_res.sample = s1_zero_reg ? '0 : rd_data_reg;
        enq_res.last   = s1_last_reg;
        enq_res.status = s1_st_reg;
        enq_res.held   = s1_held_reg;
    end

    // two-entry result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wptr_reg <= 1'b0;
            q_rptr_reg <= 1'b0;
            q_cnt_reg  <= '0;
        end else begin
            if (s1_v_reg) begin
                q_wptr_reg <= !q_wptr_reg;
            end
            if (pop) begin
                q_rptr_reg <= !q_rptr_reg;
            end
            q_cnt_reg <= occ[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_v_reg) begin
            q_reg[q_wptr_reg] <= enq_res;
        end
    end

    assign out_valid = (q_cnt_reg != '0);
    assign out_res   = q_reg[q_rptr_reg];

endmodule

`default_nettype wire

@@ rtl/audio_frame_ring_with_overlap.sv @@
// audio_frame_ring_with_overlap: top level of the overlapping frame ring
// depends on afro_pkg, afro_ctrl and afro_dp
// - s_ channel: one beat is one request; s_tuser selects the mode (write
//   sample, overlap read, pop frame, clear overlap offset), s_tdata holds the
//   raw 32-bit microphone word, used only by sample writes
// - m_ channel: one beat per result; m_tlast marks the final beat of the run
//   a request causes, m_tuser gives its status
// - cfg_ channel: always ready; user writes hop_length only while the block is idle
// result path and rate
// - a request that yields one result (write, offset clear, too few frames)
//   shows it on m_ after the read stage and the result queue; such requests
//   are taken back to back, one per cycle, while m_ does not stall
// - a frame read yields FRAME_LEN beats, one per cycle while m_ does not
//   stall, each through the read stage and the result queue; s_tready stays
//   low until the run has issued its last beat
// reset and stall
// - aresetn clears pointers, counts and offset, hop_length returns to 32;
//   the frame store keeps its contents and needs no clearing
// - a stalled m_ side fills the two-beat result queue, after which the run
//   and s_tready hold until m_tready returns; no beat is lost
`default_nettype none

module audio_frame_ring_with_overlap
    import afro_pkg::*;
#(
    parameter int FRAME_LEN  = 64,
    parameter int RING_SLOTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [31:0] raw_word
    input  wire logic [1:0]  s_tuser,  // [1:0] mode
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // [20:0] sample, [24:21] frames_held, rest zero
    output logic             m_tlast,
    output logic [2:0]       m_tuser,  // [2:0] status
    // hop length register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data  // [6:0] hop_length
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    result_t res;
    logic    pop;

    assign cfg_ready = 1'b1;
    assign pop       = m_tvalid && m_tready;

    // sequencer
    afro_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage, pointers and result queue
    afro_dp #(
        .FRAME_LEN  (FRAME_LEN),
        .RING_SLOTS (RING_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .raw_word  (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_hop   (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    // pack result fields, sample lowest
    assign m_tdata = {7'd0, res.held, res.sample};
    assign m_tlast = res.last;
    assign m_tuser = res.status;

endmodule

`default_nettype wire

@@ rtl/afro_chk.sv @@
// afro_chk: port-level checks of the overlapping frame ring
// depends on afro_pkg; bound to audio_frame_ring_with_overlap below
`default_nettype none

module afro_chk
    import afro_pkg::*;
#(
    parameter int RING_SLOTS = 8
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [2:0]  m_tuser
);

    // results are flushed by reset
    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // a status-only beat is a single-beat run with zero sample
    a_status_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_SAMPLE) |-> (m_tlast && m_tdata[20:0] == '0))
        else $error("status beat carries sample or lacks last");

    // held frames stay below ring size and status stays in range
    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:21] <= 4'(RING_SLOTS - 1) && m_tuser <= ST_DONE
                      && m_tdata[31:25] == '0))
        else $error("frames_held or status out of range");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tlast) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind audio_frame_ring_with_overlap afro_chk #(
    .RING_SLOTS (RING_SLOTS)
) u_afro_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ sim/fring_check_pkg.sv @@
// fring_check_pkg: bit-accurate mirror of the overlapping audio frame ring
// predicts the result beats of each accepted request and checks them in order
// depends on afro_pkg for widths, mode codes, status codes and result_t
package fring_check_pkg;
    import afro_pkg::*;

    localparam int FRAME_LEN   = 64;
    localparam int RING_SLOTS  = 8;
    localparam int MAX_REPORTS = 10;

    class frame_ring_mirror;
        logic [SAMPLE_W-1:0] frames [RING_SLOTS*FRAME_LEN];
        int unsigned         wr_slot;
        int unsigned         rd_slot;
        int unsigned         held;
        int unsigned         fill;
        int unsigned         offset;
        logic [HOP_W-1:0]    hop;
        result_t             run_beats[$];
        result_t             pending_beats[$];
        int unsigned         errors;
        int unsigned         beats_checked;
        int unsigned         frames_stored;
        int unsigned         frames_lost;
        int unsigned         joined_reads;
        int unsigned         whole_reads;
        int unsigned         refused_reads;
        int unsigned         bad_hop_reads;
        int unsigned         requests [4];

        function new();
            wr_slot       = 0;
            rd_slot       = 0;
            held          = 0;
            fill          = 0;
            offset        = 0;
            hop           = HOP_RESET;
            errors        = 0;
            beats_checked = 0;
            frames_stored = 0;
            frames_lost   = 0;
            joined_reads  = 0;
            whole_reads   = 0;
            refused_reads = 0;
            bad_hop_reads = 0;
            foreach (requests[i]) requests[i] = 0;
        endfunction

        function void set_hop(logic [HOP_W-1:0] value);
            hop = value;
        endfunction

        function void add_beat(logic [SAMPLE_W-1:0] smp, logic lst, logic [STAT_W-1:0] st);
            result_t b;
            b.sample = smp;
            b.last   = lst;
            b.status = st;
            b.held   = '0;
            run_beats.push_back(b);
        endfunction

        // work out the beats one request causes and queue them
        function void note_request(logic [MODE_W-1:0] mode, logic [RAW_W-1:0] raw);
            int unsigned       nxt_off;
            int unsigned       following;
            logic [STAT_W-1:0] st;
            run_beats.delete();
            requests[mode]++;
            case (mode)
                MODE_WRITE: begin
                    frames[wr_slot*FRAME_LEN + fill] = raw[RAW_W-1:SHIFT];
                    fill++;
                    st = ST_DONE;
                    if (fill == FRAME_LEN) begin
                        fill    = 0;
                        wr_slot = (wr_slot + 1) % RING_SLOTS;
                        if (wr_slot == rd_slot) begin
                            rd_slot = (rd_slot + 1) % RING_SLOTS;
                            st      = ST_LOST;
                            frames_lost++;
                        end else begin
                            held++;
                            st = ST_STORED;
                            frames_stored++;
                        end
                    end
                    add_beat('0, 1'b1, st);
                end
                MODE_OVERLAP: begin
                    if (hop == 0 || hop > FRAME_LEN) begin
                        bad_hop_reads++;
                        for (int i = 0; i < FRAME_LEN; i++)
                            add_beat('0, i == FRAME_LEN - 1, ST_SAMPLE);
                    end else begin
                        nxt_off = (offset + hop) % FRAME_LEN;
                        if (nxt_off == 0) begin
                            if (held < 1) begin
                                refused_reads++;
                                add_beat('0, 1'b1, ST_FEW);
                            end else begin
                                whole_reads++;
                                offset = 0;
                                for (int i = 0; i < FRAME_LEN; i++)
                                    add_beat(frames[rd_slot*FRAME_LEN + i],
                                             i == FRAME_LEN - 1, ST_SAMPLE);
                            end
                        end else if (held < 2) begin
                            refused_reads++;
                            add_beat('0, 1'b1, ST_FEW);
                        end else begin
                            joined_reads++;
                            following = (rd_slot + 1) % RING_SLOTS;
                            offset    = nxt_off;
                            for (int i = nxt_off; i < FRAME_LEN; i++)
                                add_beat(frames[rd_slot*FRAME_LEN + i], 1'b0, ST_SAMPLE);
                            for (int i = 0; i < nxt_off; i++)
                                add_beat(frames[following*FRAME_LEN + i], 1'b0, ST_SAMPLE);
                            run_beats[run_beats.size()-1].last = 1'b1;
                            rd_slot = following;
                            held--;
                        end
                    end
                end
                MODE_POP: begin
                    if (held < 1) begin
                        refused_reads++;
                        add_beat('0, 1'b1, ST_FEW);
                    end else begin
                        for (int i = 0; i < FRAME_LEN; i++)
                            add_beat(frames[rd_slot*FRAME_LEN + i], i == FRAME_LEN - 1,
                                     ST_SAMPLE);
                        rd_slot = (rd_slot + 1) % RING_SLOTS;
                        held--;
                    end
                end
                default: begin
                    offset = 0;
                    add_beat('0, 1'b1, ST_DONE);
                end
            endcase
            foreach (run_beats[k]) begin
                run_beats[k].held = HELD_W'(held);
                pending_beats.push_back(run_beats[k]);
            end
        endfunction

        function void check_beat(logic [SAMPLE_W-1:0] smp, logic lst,
                                 logic [STAT_W-1:0] st, logic [HELD_W-1:0] hd);
            result_t want;
            beats_checked++;
            if (pending_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with nothing outstanding: sample %0d last %0b status %0d held %0d",
                             $time, $signed(smp), lst, st, hd);
                return;
            end
            want = pending_beats.pop_front();
            if (smp !== want.sample || lst !== want.last || st !== want.status ||
                hd !== want.held) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: mismatch: expected sample %0d last %0b status %0d held %0d,",
                              " got sample %0d last %0b status %0d held %0d"},
                             $time, $signed(want.sample), want.last, want.status, want.held,
                             $signed(smp), lst, st, hd);
            end
        endfunction

        // leftover beats at the end count as failures
        function int unsigned close_out();
            if (pending_beats.size() != 0) begin
                errors += pending_beats.size();
                $display("%0d result beats never arrived", pending_beats.size());
            end
            return errors;
        endfunction
    endclass

endpackage

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for audio_frame_ring_with_overlap
// drives requests, hop writes and result backpressure; checks every beat
// depends on afro_pkg, fring_check_pkg and the rtl of the block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import afro_pkg::*;
    import fring_check_pkg::*;

    localparam int HOLD_CYCLES   = 300;    // long m_tready hold-off
    localparam int DRAIN_LIMIT   = 20000;  // cap on the final drain wait
    localparam int SETTLE_CYCLES = 10;     // settling margin after the final drain

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [31:0] raw_word
    logic [1:0]  s_tuser   = '0;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [20:0] sample, [24:21] frames_held
    logic        m_tlast;
    logic [2:0]  m_tuser;          // [2:0] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;   // [6:0] hop_length

    // idle percentages per side, changed between phases
    int unsigned tx_idle_pct  = 26;
    int unsigned rx_idle_pct  = 69;
    // position in the frame being filled, tracked on the sending side
    int unsigned fill_track   = 0;
    int unsigned items_sent   = 0;
    int unsigned hold_left    = 0;
    bit          hold_request = 1'b0;
    int unsigned long_holds   = 0;

    frame_ring_mirror ring;

    audio_frame_ring_with_overlap dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        #(30_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // handshake monitor: values read at the edge are the ones the block saw
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                ring.set_hop(cfg_data);
            if (s_tvalid && s_tready)
                ring.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                ring.check_beat(m_tdata[20:0], m_tlast, m_tuser, m_tdata[24:21]);
        end
    end

    // result side: random stalls, plus one long hold-off when asked for
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
                long_holds++;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // one request beat; random idle cycles come before it, never between
    // lowering and raising valid in the same step
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [RAW_W-1:0] raw);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (mode == MODE_WRITE)
            fill_track = (fill_track + 1) % FRAME_LEN;
    endtask

    task automatic write_hop(input logic [HOP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stop offering requests, then at least one edge first, so the last
    // accepted request is already noted
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (ring.pending_beats.size() != 0);
    endtask

    // mostly well-formed traffic: whole frame fills and reads, some partial
    // fills, and a little noise with random mode; bursts stay within room
    task automatic random_op(input int unsigned room);
        int unsigned pick;
        int unsigned burst;
        pick = $urandom_range(99);
        if (pick < 35) begin
            burst = FRAME_LEN - fill_track;
            if (burst > room)
                burst = room;
            if (pick >= 28)
                burst = $urandom_range(burst, 1);
            repeat (burst) send_request(MODE_WRITE, $urandom);
        end else if (pick < 62) begin
            send_request(MODE_OVERLAP, $urandom);
        end else if (pick < 80) begin
            send_request(MODE_POP, $urandom);
        end else if (pick < 88) begin
            send_request(MODE_OFFRST, $urandom);
        end else if (pick < 96) begin
            send_request(MODE_WRITE, $urandom);
        end else begin
            send_request(MODE_W'($urandom_range(3)), $urandom);
        end
    endtask

    initial begin
        int unsigned hop_plan [6];
        int unsigned items_plan [6];
        logic [31:0] corner_words [9];
        int unsigned waited;
        int unsigned fails;
        ring = new();
        // hop extremes, out-of-range hops, a random one, then the reset value
        hop_plan     = '{1, 64, 0, 127, 0, 32};
        // running request count at the end of each phase
        items_plan   = '{80, 130, 150, 170, 250, 310};
        hop_plan[4]  = $urandom_range(63, 2);
        corner_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                         32'h0000_07FF, 32'h0000_0800, 32'hFFFF_F800, 32'h5555_5555,
                         32'hAAAA_AAAA};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: offset clear, reads on an empty ring, sign and shift corners
        send_request(MODE_OFFRST, 32'h0000_0000);
        send_request(MODE_POP, 32'h0000_0000);
        send_request(MODE_OVERLAP, 32'h0000_0000);
        foreach (corner_words[i]) send_request(MODE_WRITE, corner_words[i]);
        send_request(MODE_OFFRST, 32'hFFFF_FFFF);
        send_request(MODE_POP, 32'hFFFF_FFFF);
        send_request(MODE_OVERLAP, 32'hFFFF_FFFF);

        for (int p = 0; p < 6; p++) begin
            tx_idle_pct = (p == 0) ? 26 : (p < 3) ? 69 : 0;
            rx_idle_pct = (p == 0) ? 69 : (p < 3) ? 26 : 0;
            // hop_length only changes with nothing in flight
            wait_drained();
            write_hop(HOP_W'(hop_plan[p]));
            // backpressure: result side holds off while writes keep coming
            if (p == 4) begin
                hold_request = 1'b1;
                repeat (40) send_request(MODE_WRITE, $urandom);
                send_request(MODE_POP, $urandom);
            end
            while (items_sent < items_plan[p])
                random_op(items_plan[p] - items_sent);
        end

        s_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (ring.pending_beats.size() != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display({"requests: %0d writes, %0d overlap reads, %0d pops, %0d offset clears;",
                  " %0d beats checked"},
                 ring.requests[MODE_WRITE], ring.requests[MODE_OVERLAP],
                 ring.requests[MODE_POP], ring.requests[MODE_OFFRST], ring.beats_checked);
        $display({"frames stored %0d, dropped %0d; reads joined %0d, whole %0d,",
                  " refused %0d, bad hop %0d; long stalls %0d"},
                 ring.frames_stored, ring.frames_lost, ring.joined_reads, ring.whole_reads,
                 ring.refused_reads, ring.bad_hop_reads, long_holds);
        fails = ring.close_out();
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
